FILE: rtl/core/vks_pkg.sv
// Shared types and constants for the vibrator kick-start timer.
package vks_pkg;

	// Field widths
	localparam int unsigned MsW    = 16;
	localparam int unsigned LevelW = 12;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_KICK_DURATION = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KICK_LEVEL    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RUN_LEVEL     = 2'd2;

	// Reset values of the configuration registers
	localparam logic [MsW-1:0]    KICK_DURATION_RST = 16'd50;
	localparam logic [LevelW-1:0] KICK_LEVEL_RST    = 12'd3100;
	localparam logic [LevelW-1:0] RUN_LEVEL_RST     = 12'd3000;

	// Command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_ENABLE = 1'b1;

	// Motor phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_KICK = 3'b010,
		PH_RUN  = 3'b100
	} vks_phase_t;

	// Timer state
	typedef struct packed {
		vks_phase_t        phase;
		logic [MsW-1:0]    timer;
		logic [MsW-1:0]    pending;
		logic [LevelW-1:0] level;
	} vks_state_t;

	// Configuration values
	typedef struct packed {
		logic [MsW-1:0]    kick_duration;
		logic [LevelW-1:0] kick_level;
		logic [LevelW-1:0] run_level;
	} vks_cfg_t;

	// One result item
	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              active;
		logic [MsW-1:0]    remaining;
	} vks_result_t;

endpackage

FILE: rtl/core/vks_step.sv
// Next-state and result logic for one tick or enable item.
module vks_step import vks_pkg::*; (
	input  vks_state_t        cur,
	input  vks_cfg_t          cfg,
	input  logic              command,
	input  logic [MsW-1:0]    duration_ms,
	output vks_state_t        nxt,
	output vks_result_t       res
);

	logic [MsW-1:0] timer_dec;
	logic [MsW:0]   rem_sum;

	// Phase update
	always_comb begin
		nxt = cur;
		timer_dec = (cur.timer != '0) ? cur.timer - 1'b1 : '0;
		if (command == CMD_ENABLE) begin
			if (duration_ms == '0) begin
				nxt.phase   = PH_IDLE;
				nxt.timer   = '0;
				nxt.pending = '0;
				nxt.level   = '0;
			end else begin
				nxt.phase = PH_KICK;
				nxt.level = cfg.kick_level;
				if (duration_ms > cfg.kick_duration) begin
					nxt.timer   = cfg.kick_duration;
					nxt.pending = duration_ms - cfg.kick_duration;
				end else begin
					nxt.timer   = duration_ms;
					nxt.pending = '0;
				end
			end
		end else if (cur.phase != PH_IDLE) begin
			nxt.timer = timer_dec;
			if (timer_dec == '0) begin
				if (cur.phase == PH_KICK && cur.pending != '0) begin
					// kick over, run for the held time
					nxt.phase   = PH_RUN;
					nxt.timer   = cur.pending;
					nxt.pending = '0;
					nxt.level   = cfg.run_level;
				end else begin
					nxt.phase   = PH_IDLE;
					nxt.timer   = '0;
					nxt.pending = '0;
					nxt.level   = '0;
				end
			end
		end
	end

	// Result from the updated state; the sum is saturated to the field
	always_comb begin
		rem_sum = {1'b0, nxt.pending} + {1'b0, nxt.timer};
		res.level  = nxt.level;
		res.active = (nxt.phase != PH_IDLE);
		if (nxt.phase == PH_IDLE)
			res.remaining = '0;
		else if (rem_sum[MsW])
			res.remaining = '1;
		else
			res.remaining = rem_sum[MsW-1:0];
	end

endmodule

FILE: rtl/core/vibrator_kick_start_timer.sv
// Top level of the vibrator kick-start timer: item registers, state and config.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_stall | command, duration_ms
//  out      | out_valid/out_stall | drive_level_mv, motor_active, remaining_ms
//  config   | cfg_we              | cfg_index, cfg_data
//
// One item per cycle while no result is stalled; a result is registered after its item
// is accepted (input register, then result register updated together with the state).
// Reset clears state and loads the configuration defaults; no clearing pass.
// A stalled result holds the input register; in_stall rises only while both
// registers hold an item and out_stall is high.
module vibrator_kick_start_timer import vks_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// item input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [MsW-1:0]      duration_ms,
	// result output
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LevelW-1:0]   drive_level_mv,
	output logic                motor_active,
	output logic [MsW-1:0]      remaining_ms,
	// configuration write
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	vks_cfg_t       cfg_q;
	vks_state_t     state_q;
	vks_state_t     state_nxt;
	vks_result_t    res_nxt;
	vks_result_t    res_q;
	logic           out_valid_q;
	logic           valid_s1;
	logic           command_s1;
	logic [MsW-1:0] duration_s1;
	logic           advance;
	logic           in_take;

	// Pipeline moves whenever the result register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kick_duration <= KICK_DURATION_RST;
			cfg_q.kick_level    <= KICK_LEVEL_RST;
			cfg_q.run_level     <= RUN_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KICK_DURATION: cfg_q.kick_duration <= cfg_data;
				CFG_KICK_LEVEL:    cfg_q.kick_level    <= cfg_data[LevelW-1:0];
				CFG_RUN_LEVEL:     cfg_q.run_level     <= cfg_data[LevelW-1:0];
				default: ;
			endcase
		end
	end

	// Input register; an empty stage fills even while the result is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || in_take) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1  <= command;
			duration_s1 <= duration_ms;
		end
	end

	// Step logic
	vks_step u_step (
		.cur         (state_q),
		.cfg         (cfg_q),
		.command     (command_s1),
		.duration_ms (duration_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_IDLE;
			state_q.timer   <= '0;
			state_q.pending <= '0;
			state_q.level   <= '0;
			out_valid_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign drive_level_mv = res_q.level;
	assign motor_active   = res_q.active;
	assign remaining_ms   = res_q.remaining;

	// Checks
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.timer == '0 && state_q.pending == '0
			&& state_q.level == '0)
		else $error("idle phase with leftover timer, pending time or level");

	a_run_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_RUN |-> state_q.pending == '0)
		else $error("run phase with pending time");

	a_stopped_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !motor_active |-> remaining_ms == '0 && drive_level_mv == '0)
		else $error("stopped result with nonzero time or level");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall && valid_s1)
		else $error("input stalled while the result register can move");

endmodule
